// File: design/tme_pkg.sv
// shared types, constants and codes for the trimmed mean and smoothing block
package tme_pkg;

    // window geometry; storage widths are sized for the largest window
    localparam int WINDOW_DEF = 5;
    localparam int WINDOW_MAX = 8;
    localparam int WIN_LOG    = $clog2(WINDOW_MAX);
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

    // field widths
    localparam int POS_W    = 32;
    localparam int VEL_W    = 32;
    localparam int TQ_W     = 16;
    localparam int KP_W     = 23;
    localparam int VSUM_W   = VEL_W + WIN_LOG;
    localparam int TSUM_W   = TQ_W + WIN_LOG;
    localparam int Q_FRAC   = 16;
    localparam int WEIGHT_W = 17;
    localparam int VMEAN_W  = VEL_W + Q_FRAC;
    localparam int TMEAN_W  = TQ_W + Q_FRAC;

    // mean divider: numerator is |sum| * 2^17 + div, denominator 2 * div
    localparam int V_NUM_W = VSUM_W + Q_FRAC + 1;
    localparam int T_NUM_W = TSUM_W + Q_FRAC + 1;
    localparam int DEN_W   = CNT_W + 1;
    localparam int DIGIT_W = 8;

    // trimming starts at five held entries and drops min and max
    localparam logic [CNT_W-1:0] TRIM_FROM = CNT_W'(5);
    localparam logic [CNT_W-1:0] TRIM_DROP = CNT_W'(2);

    // weights, Q1.16
    localparam logic [WEIGHT_W-1:0] ONE_Q16        = WEIGHT_W'(65536);
    localparam logic [WEIGHT_W-1:0] VEL_WEIGHT_RST = WEIGHT_W'(9830);
    localparam logic [WEIGHT_W-1:0] TQ_WEIGHT_RST  = WEIGHT_W'(13107);

    // rounding offsets for Q.16 to integer, half away from zero
    localparam int HALF_Q16    = 32768;
    localparam int HALF_Q16_LO = 32767;

    // position / 1000 by reciprocal: ceil(2^41 / 1000), exact for 32-bit magnitudes
    localparam logic [POS_W-1:0] KP_RECIP = 32'd2199023256;
    localparam int               KP_SHIFT = 41;
    localparam int               KP_BIAS  = 500;

    // configuration register indexes
    localparam int                   CFG_IDX_W      = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TQ_WEIGHT  = 2'd1;

    typedef struct packed {
        logic                    restart;
        logic signed [POS_W-1:0] position_sample;
        logic signed [VEL_W-1:0] velocity_sample;
        logic signed [TQ_W-1:0]  torque_sample;
    } t_in_req;

    typedef struct packed {
        logic signed [KP_W-1:0]  position_kpulse;
        logic signed [VEL_W-1:0] smoothed_velocity;
        logic signed [TQ_W-1:0]  smoothed_torque;
    } t_out_rsp;

    // one window entry held by a cell
    typedef struct packed {
        logic                    vld;
        logic signed [VEL_W-1:0] vel;
        logic signed [TQ_W-1:0]  tq;
    } t_entry;

    // running aggregate passed from cell to cell
    typedef struct packed {
        logic signed [VSUM_W-1:0] vsum;
        logic signed [VEL_W-1:0]  vmin;
        logic signed [VEL_W-1:0]  vmax;
        logic signed [TSUM_W-1:0] tsum;
        logic signed [TQ_W-1:0]   tmin;
        logic signed [TQ_W-1:0]   tmax;
        logic [CNT_W-1:0]         cnt;
    } t_agg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_TRIM,
        S_DIV_GO,
        S_DIV_WAIT,
        S_SIGN,
        S_EMA_GO,
        S_EMA_WAIT,
        S_DONE
    } t_state;

endpackage

// File: design/tme_cell.sv
// window cell: holds one entry and folds it into the passing aggregate
module tme_cell import tme_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  logic   i_clear,
    input  t_entry i_entry,
    output t_entry o_entry,
    input  t_agg   i_agg,
    output t_agg   o_agg
);

    t_entry r_entry;
    t_agg   r_agg;
    t_agg   n_agg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            if (i_clear) begin
                r_entry.vld <= 1'b0;
            end else begin
                r_entry <= i_entry;
            end
        end
    end

    always_comb begin
        n_agg = i_agg;
        if (r_entry.vld) begin
            n_agg.vsum = i_agg.vsum + VSUM_W'(r_entry.vel);
            n_agg.tsum = i_agg.tsum + TSUM_W'(r_entry.tq);
            n_agg.cnt  = CNT_W'(i_agg.cnt + 1'b1);
            if (i_agg.cnt == '0 || r_entry.vel < i_agg.vmin) begin
                n_agg.vmin = r_entry.vel;
            end
            if (i_agg.cnt == '0 || r_entry.vel > i_agg.vmax) begin
                n_agg.vmax = r_entry.vel;
            end
            if (i_agg.cnt == '0 || r_entry.tq < i_agg.tmin) begin
                n_agg.tmin = r_entry.tq;
            end
            if (i_agg.cnt == '0 || r_entry.tq > i_agg.tmax) begin
                n_agg.tmax = r_entry.tq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_agg <= n_agg;
    end

    assign o_entry = r_entry;
    assign o_agg   = r_agg;

endmodule

// File: design/tme_div.sv
// small-divisor divider, one byte of quotient per cycle
module tme_div import tme_pkg::*; #(
    parameter int NUM_W = V_NUM_W,
    parameter int DIV_W = DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DIV_W-1:0] i_den,
    output logic             o_busy,
    output logic [NUM_W-1:0] o_quo
);

    localparam int STEPS  = (NUM_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W  = STEPS * DIGIT_W;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic [PAD_W-1:0]   r_num;
    logic [PAD_W-1:0]   r_quo;
    logic [DIV_W-1:0]   r_rem;
    logic [DIV_W-1:0]   r_den;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic [DIV_W-1:0]   n_rem;
    logic [DIGIT_W-1:0] n_digit;

    // restoring division over the top byte of the shifting numerator
    always_comb begin
        logic [DIV_W-1:0] rem;
        logic [DIV_W:0]   part;
        rem     = r_rem;
        n_digit = '0;
        for (int b = 0; b < DIGIT_W; b++) begin
            part = {rem, r_num[PAD_W-1-b]};
            if (part >= {1'b0, r_den}) begin
                part                   = part - {1'b0, r_den};
                n_digit[DIGIT_W-1-b]   = 1'b1;
            end
            rem = part[DIV_W-1:0];
        end
        n_rem = rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= STEP_W'(r_step + 1'b1);
            if (r_step == STEP_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= PAD_W'(i_num);
            r_quo <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= r_num << DIGIT_W;
            r_quo <= {r_quo[PAD_W-DIGIT_W-1:0], n_digit};
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo[NUM_W-1:0];

endmodule

// File: design/tme_ema.sv
// exponential smoother step: s += round((mean - s) * w / 2^16), four stages; a seed load sets s to mean
module tme_ema import tme_pkg::*; #(
    parameter int S_W = VMEAN_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic                i_seed,
    input  logic signed [S_W-1:0] i_mean,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_done,
    output logic signed [S_W-1:0] o_s
);

    localparam int M_W   = S_W + 1;
    localparam int HI_W  = M_W - Q_FRAC;
    localparam int PHI_W = HI_W + WEIGHT_W;
    localparam int PLO_W = Q_FRAC + WEIGHT_W + 1;

    logic signed [S_W-1:0] r_s;
    logic signed [S_W-1:0] r_mean;
    logic signed [M_W-1:0] r_d;
    logic                  r_seed;
    logic [WEIGHT_W-1:0]   r_w;
    logic [M_W-1:0]        r_m;
    logic                  r_neg;
    logic [PHI_W-1:0]      r_phi;
    logic [PLO_W-1:0]      r_plo;
    logic [2:0]            r_v;
    logic                  r_done;
    logic [M_W-1:0]        w_step;
    logic [M_W-1:0]        w_s_ext;
    logic [M_W-1:0]        w_s_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_done <= 1'b0;
        end else begin
            r_v    <= {r_v[1:0], i_load};
            r_done <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_d    <= M_W'(i_mean) - M_W'(r_s);
            r_mean <= i_mean;
            r_seed <= i_seed;
            // weights above one act as one
            r_w    <= i_weight[WEIGHT_W-1] ? ONE_Q16 : i_weight;
        end
        r_neg <= r_d[M_W-1];
        r_m   <= r_d[M_W-1] ? M_W'(-r_d) : M_W'(r_d);
        r_phi <= PHI_W'(r_m[M_W-1:Q_FRAC]) * PHI_W'(r_w);
        r_plo <= PLO_W'(r_m[Q_FRAC-1:0]) * PLO_W'(r_w) + PLO_W'(HALF_Q16);
    end

    assign w_step  = M_W'(r_phi + PHI_W'(r_plo[PLO_W-1:Q_FRAC]));
    assign w_s_ext = {r_s[S_W-1], r_s};
    assign w_s_new = r_neg ? (w_s_ext - w_step) : (w_s_ext + w_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s <= '0;
        end else if (r_v[2]) begin
            r_s <= r_seed ? r_mean : w_s_new[S_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_s    = r_s;

endmodule

// File: design/trimmed_mean_ema_smoother.sv
// top level: trimmed moving average of velocity and torque, exponential smoothing
// o_valid rises once a request has passed the scan, trim, divide, sign and smoothing states
// only one request is taken at a time; a finished result
//   waits in the output register while the next request is taken
// the wait per request is set by the scan through the cell row and the
//   seven byte steps of the velocity mean divider
// reset (synchronous, active low): windows empty, smoother unseeded, output empty,
//   weights 9830 and 13107 (0.15 and 0.2)
module trimmed_mean_ema_smoother import tme_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_req              i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_rsp             o_rsp,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WEIGHT_W-1:0]  i_cfg_data
);

    localparam int SCAN_W = $clog2(WINDOW);

    // control
    t_state              r_state;
    t_state              n_state;
    logic [SCAN_W-1:0]   r_scan_cnt;
    logic                r_seeded;
    logic                w_accept;
    logic                w_div_go;
    logic                w_ema_go;
    logic                w_load_out;

    // configuration
    logic [WEIGHT_W-1:0] r_vel_weight;
    logic [WEIGHT_W-1:0] r_tq_weight;

    // cell row
    t_entry              w_ent [WINDOW];
    t_agg                w_agg [WINDOW+1];
    t_agg                w_last;
    logic                w_trim;

    // trimmed sums and divider
    logic signed [VSUM_W-1:0] r_vsum;
    logic signed [TSUM_W-1:0] r_tsum;
    logic [CNT_W-1:0]         r_div;
    logic [VSUM_W-1:0]        w_vmag;
    logic [TSUM_W-1:0]        w_tmag;
    logic [V_NUM_W-1:0]       w_vquo;
    logic [T_NUM_W-1:0]       w_tquo;
    logic                     w_vbusy;
    logic                     w_tbusy;

    // means and smoother
    logic signed [VMEAN_W-1:0] r_vmean;
    logic signed [TMEAN_W-1:0] r_tmean;
    logic signed [VMEAN_W-1:0] w_vs;
    logic signed [TMEAN_W-1:0] w_ts;
    logic                      w_vdone;
    logic                      w_tdone;
    logic [VMEAN_W:0]          w_vround;
    logic [TMEAN_W:0]          w_tround;

    // position path
    logic signed [POS_W-1:0] r_pos;
    logic [POS_W-1:0]        r_pmag;
    logic [2*POS_W-1:0]      r_pprod;
    logic [POS_W:0]          w_pos_ext;
    logic [KP_W-1:0]         w_kp_mag;
    logic [KP_W-1:0]         w_kp;

    // output register
    t_out_rsp r_rsp;
    logic     r_out_vld;

    assign w_accept = i_valid & o_ready;

    // ---------------- configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_weight <= VEL_WEIGHT_RST;
            r_tq_weight  <= TQ_WEIGHT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_VEL_WEIGHT: r_vel_weight <= i_cfg_data;
                REG_TQ_WEIGHT:  r_tq_weight  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (w_accept) n_state = S_SCAN;
            S_SCAN:     if (r_scan_cnt == SCAN_W'(WINDOW - 1)) n_state = S_TRIM;
            S_TRIM:     n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (!w_vbusy && !w_tbusy) n_state = S_SIGN;
            S_SIGN:     n_state = S_EMA_GO;
            S_EMA_GO:   n_state = S_EMA_WAIT;
            S_EMA_WAIT: if (w_vdone) n_state = S_DONE;
            S_DONE:     if (!r_out_vld || i_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        w_div_go   = 1'b0;
        w_ema_go   = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE:   o_ready    = 1'b1;
            S_DIV_GO: w_div_go   = 1'b1;
            S_EMA_GO: w_ema_go   = 1'b1;
            S_DONE:   w_load_out = !r_out_vld || i_ready;
            default: ;
        endcase
    end

    // scan counter: the aggregate passes the register of every cell before it reaches the row's end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt <= '0;
        end else if (r_state == S_SCAN) begin
            r_scan_cnt <= SCAN_W'(r_scan_cnt + 1'b1);
        end else begin
            r_scan_cnt <= '0;
        end
    end

    // smoother seeds from the first mean after reset or restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
        end else if (w_accept && i_req.restart) begin
            r_seeded <= 1'b0;
        end else if (r_state == S_EMA_WAIT && w_vdone) begin
            r_seeded <= 1'b1;
        end
    end

    // ---------------- cell row ----------------
    // newest sample enters cell 0, the oldest drops off the far end;
    // a restart empties every cell but the one taking the new sample
    assign w_ent[0] = '{vld: 1'b1, vel: i_req.velocity_sample, tq: i_req.torque_sample};
    assign w_agg[0] = '0;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i < WINDOW - 1) begin : g_mid
            tme_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_clear ((i != 0) && i_req.restart),
                .i_entry (w_ent[i]),
                .o_entry (w_ent[i+1]),
                .i_agg   (w_agg[i]),
                .o_agg   (w_agg[i+1])
            );
        end else begin : g_end
            tme_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_clear ((i != 0) && i_req.restart),
                .i_entry (w_ent[i]),
                .o_entry (),
                .i_agg   (w_agg[i]),
                .o_agg   (w_agg[i+1])
            );
        end
    end

    assign w_last = w_agg[WINDOW];
    assign w_trim = (w_last.cnt >= TRIM_FROM);

    // ---------------- trim ----------------
    always_ff @(posedge i_clk) begin
        if (r_state == S_TRIM) begin
            if (w_trim) begin
                r_vsum <= w_last.vsum - VSUM_W'(w_last.vmin) - VSUM_W'(w_last.vmax);
                r_tsum <= w_last.tsum - TSUM_W'(w_last.tmin) - TSUM_W'(w_last.tmax);
                r_div  <= CNT_W'(w_last.cnt - TRIM_DROP);
            end else begin
                r_vsum <= w_last.vsum;
                r_tsum <= w_last.tsum;
                r_div  <= w_last.cnt;
            end
        end
    end

    // ---------------- mean division ----------------
    // mean = (|sum| * 2^17 + div) / (2 * div), sign restored afterwards
    assign w_vmag = r_vsum[VSUM_W-1] ? VSUM_W'(-r_vsum) : VSUM_W'(r_vsum);
    assign w_tmag = r_tsum[TSUM_W-1] ? TSUM_W'(-r_tsum) : TSUM_W'(r_tsum);

    tme_div #(
        .NUM_W (V_NUM_W),
        .DIV_W (DEN_W)
    ) u_vdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   ({w_vmag, (Q_FRAC + 1)'(r_div)}),
        .i_den   ({r_div, 1'b0}),
        .o_busy  (w_vbusy),
        .o_quo   (w_vquo)
    );

    tme_div #(
        .NUM_W (T_NUM_W),
        .DIV_W (DEN_W)
    ) u_tdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_num   ({w_tmag, (Q_FRAC + 1)'(r_div)}),
        .i_den   ({r_div, 1'b0}),
        .o_busy  (w_tbusy),
        .o_quo   (w_tquo)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == S_SIGN) begin
            r_vmean <= r_vsum[VSUM_W-1] ? VMEAN_W'(-w_vquo[VMEAN_W-1:0])
                                        : VMEAN_W'(w_vquo[VMEAN_W-1:0]);
            r_tmean <= r_tsum[TSUM_W-1] ? TMEAN_W'(-w_tquo[TMEAN_W-1:0])
                                        : TMEAN_W'(w_tquo[TMEAN_W-1:0]);
        end
    end

    // ---------------- smoothers ----------------
    tme_ema #(
        .S_W (VMEAN_W)
    ) u_vema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_ema_go),
        .i_seed   (!r_seeded),
        .i_mean   (r_vmean),
        .i_weight (r_vel_weight),
        .o_done   (w_vdone),
        .o_s      (w_vs)
    );

    tme_ema #(
        .S_W (TMEAN_W)
    ) u_tema (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_ema_go),
        .i_seed   (!r_seeded),
        .i_mean   (r_tmean),
        .i_weight (r_tq_weight),
        .o_done   (w_tdone),
        .o_s      (w_ts)
    );

    // round half away from zero: negative values take the offset one below half
    assign w_vround = {w_vs[VMEAN_W-1], w_vs}
                    + (w_vs[VMEAN_W-1] ? (VMEAN_W + 1)'(HALF_Q16_LO)
                                       : (VMEAN_W + 1)'(HALF_Q16));
    assign w_tround = {w_ts[TMEAN_W-1], w_ts}
                    + (w_ts[TMEAN_W-1] ? (TMEAN_W + 1)'(HALF_Q16_LO)
                                       : (TMEAN_W + 1)'(HALF_Q16));

    // ---------------- position in kilopulses ----------------
    // settles during the scan: |pos| + 500, then reciprocal multiply, then shift
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos <= i_req.position_sample;
        end
        r_pmag  <= r_pos[POS_W-1] ? POS_W'((POS_W + 1)'(KP_BIAS) - w_pos_ext)
                                  : POS_W'(w_pos_ext + (POS_W + 1)'(KP_BIAS));
        r_pprod <= (2 * POS_W)'(r_pmag) * (2 * POS_W)'(KP_RECIP);
    end

    assign w_pos_ext = {r_pos[POS_W-1], r_pos};
    assign w_kp_mag  = r_pprod[KP_SHIFT+KP_W-1:KP_SHIFT];
    assign w_kp      = r_pos[POS_W-1] ? KP_W'(-w_kp_mag) : w_kp_mag;

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_rsp.position_kpulse   <= w_kp;
            r_rsp.smoothed_velocity <= w_vround[VMEAN_W-1:Q_FRAC];
            r_rsp.smoothed_torque   <= w_tround[TMEAN_W-1:Q_FRAC];
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_rsp;

endmodule

// File: design/tme_checker.sv
// port-level checks for the trimmed mean smoother, bound to the top level
module tme_checker import tme_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input t_in_req              i_req,
    input logic                 o_valid,
    input logic                 i_ready,
    input t_out_rsp             o_rsp,
    input logic                 i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0] i_cfg_index,
    input logic [WEIGHT_W-1:0]  i_cfg_data
);

    localparam logic signed [KP_W-1:0] KP_MAX = 23'sd2147484;
    localparam logic signed [KP_W-1:0] KP_MIN = -23'sd2147484;

    // a waiting result holds until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed or dropped while stalled");

    // one request at a time: an accepted request closes the input
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input still open after a request was taken");

    // the input reopens only as a result is handed to the output register
    a_reopen_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_ready) && $past(i_rst_n) |-> o_valid)
        else $error("input reopened without a result");

    // position in kilopulses stays within the 32-bit range scaled by 1/1000
    a_kp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.position_kpulse <= KP_MAX) && (o_rsp.position_kpulse >= KP_MIN))
        else $error("position_kpulse out of range");

endmodule

bind trimmed_mean_ema_smoother tme_checker u_tme_checker (.*);
